@@ hw/rtl/omts_pkg.sv @@
// Shared types and constants for the optimal merge tree sorter.
`timescale 1ns / 1ps
package omts_pkg;

  localparam int DataW    = 32;
  localparam int CmdW     = 2;
  localparam int MUserW   = 2;

  // Command codes carried in the slave-side tuser
  typedef enum logic [CmdW-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_CLOSE  = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CP_SEL,
    ST_CP_GET,
    ST_MRD,
    ST_MCMP,
    ST_FIX_A,
    ST_FIX_B,
    ST_PASS_END,
    ST_O_RD,
    ST_O_WAIT
  } state_e;

  // Master-side tuser bits
  localparam int UserEmptyBit = 0;
  localparam int UserOvflBit  = 1;

endpackage

@@ hw/rtl/optimal_merge_tree_sorter.sv @@
// Optimal merge tree sorter: loads runs, merges the two shortest runs repeatedly, emits.
// Loading: push and close are accepted at one transaction per cycle.
// Finish: each pass scans the n runs, copies every other run to the destination half,
// merges the chosen pair behind them, then fixes the run table. Input is held off until
// the last result is loaded; each result is read from the store, then emitted, and
// emission waits while the master side stalls. Reset clears the state, load counters,
// drop flag and output valid; working registers, element store and run table are not cleared.
`timescale 1ns / 1ps
module optimal_merge_tree_sorter #(
  parameter int MAX_ELEMS = 64,
  parameter int MAX_RUNS  = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid_i,
  output logic                             s_tready_o,
  input  logic [omts_pkg::DataW-1:0]       s_tdata_i,  // [31:0] value
  input  logic [omts_pkg::CmdW-1:0]        s_tuser_i,  // [1:0] cmd
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  output logic [omts_pkg::DataW-1:0]       m_tdata_o,  // [31:0] value_res
  output logic                             m_tlast_o,
  output logic [omts_pkg::MUserW-1:0]      m_tuser_o   // [0] empty_res, [1] overflow
);

  localparam int PW = $clog2(MAX_ELEMS + 1);
  localparam int AW = $clog2(2 * MAX_ELEMS);
  localparam int RI = $clog2(MAX_RUNS);
  localparam int RC = $clog2(MAX_RUNS + 1);
  localparam int SW = $clog2(2 * MAX_RUNS);
  localparam int EW = 2 * PW + SW;

  // Order runs by length, then by age
  function automatic logic run_before(input logic [PW-1:0] l1, input logic [SW-1:0] q1,
                                      input logic [PW-1:0] l2, input logic [SW-1:0] q2);
    return (l1 < l2) || ((l1 == l2) && (q1 < q2));
  endfunction

  omts_pkg::state_e state_q, state_d;

  logic [RC-1:0] run_cnt_q, run_cnt_d;
  logic [PW-1:0] total_q, total_d;
  logic [PW-1:0] open_q, open_d;
  logic          drop_q, drop_d;
  logic [PW-1:0] tot_out_q, tot_out_d;
  logic          drop_out_q, drop_out_d;
  logic [RC-1:0] n_q, n_d;
  logic          half_q, half_d;
  logic [SW-1:0] nseq_q, nseq_d;
  logic [RC-1:0] i_q, i_d;
  logic          rd_vld_q, rd_vld_d;
  logic [RI-1:0] rd_idx_q, rd_idx_d;
  logic          have_a_q, have_a_d, have_b_q, have_b_d;
  logic [RI-1:0] a_idx_q, a_idx_d, b_idx_q, b_idx_d;
  logic [PW-1:0] a_len_q, a_len_d, b_len_q, b_len_d;
  logic [PW-1:0] a_start_q, a_start_d, b_start_q, b_start_d;
  logic [SW-1:0] a_seq_q, a_seq_d, b_seq_q, b_seq_d;
  logic [PW-1:0] pa_q, pa_d, ea_q, ea_d, pb_q, pb_d, eb_q, eb_d;
  logic [PW-1:0] w_q, w_d, mstart_q, mstart_d;
  logic          final_q, final_d;
  logic          fwd_q, fwd_d;
  logic [EW-1:0] fixa_q, fixa_d;
  logic [PW-1:0] k_q, k_d;

  logic                       m_vld_q, m_vld_d;
  logic [omts_pkg::DataW-1:0] m_data_q, m_data_d;
  logic                       m_last_q, m_last_d;
  logic [omts_pkg::MUserW-1:0] m_user_q, m_user_d;

  // Memory ports
  logic                       el_we;
  logic [AW-1:0]              el_waddr, el_raddr0, el_raddr1;
  logic [omts_pkg::DataW-1:0] el_wdata, el_rdata0, el_rdata1;
  logic                       tb_we;
  logic [RI-1:0]              tb_waddr, tb_raddr;
  logic [EW-1:0]              tb_wdata, tb_rdata;

  omts_elem_mem #(.Depth(2 * MAX_ELEMS), .AddrW(AW)) u_elem (
    .clk_i   (clk_i),
    .we_i    (el_we),
    .waddr_i (el_waddr),
    .wdata_i (el_wdata),
    .raddr0_i(el_raddr0),
    .raddr1_i(el_raddr1),
    .rdata0_o(el_rdata0),
    .rdata1_o(el_rdata1)
  );

  omts_run_tab #(.Depth(MAX_RUNS), .IdxW(RI), .DataW(EW)) u_tab (
    .clk_i  (clk_i),
    .we_i   (tb_we),
    .waddr_i(tb_waddr),
    .wdata_i(tb_wdata),
    .raddr_i(tb_raddr),
    .rdata_o(tb_rdata)
  );

  // Table entry fields
  logic [PW-1:0] e_start, e_len;
  logic [SW-1:0] e_seq;
  assign e_start = tb_rdata[PW-1:0];
  assign e_len   = tb_rdata[2*PW-1:PW];
  assign e_seq   = tb_rdata[EW-1:2*PW];

  // Half offsets for source and destination of a pass
  logic [AW-1:0] src_off, dst_off;
  assign src_off = half_q ? AW'(MAX_ELEMS) : '0;
  assign dst_off = half_q ? '0 : AW'(MAX_ELEMS);

  // Close of the open run, shared by close and finish
  logic          close_wr;
  logic [RC-1:0] rc_cl;
  logic [PW-1:0] tot_cl;
  logic          drop_cl;
  always_comb begin
    close_wr = 1'b0;
    rc_cl    = run_cnt_q;
    tot_cl   = total_q;
    drop_cl  = drop_q;
    if (open_q != '0) begin
      if (run_cnt_q < RC'(MAX_RUNS)) begin
        close_wr = 1'b1;
        rc_cl    = run_cnt_q + RC'(1);
      end else begin
        tot_cl  = total_q - open_q;
        drop_cl = 1'b1;
      end
    end
  end

  logic          out_free, take_a;
  logic [RC-1:0] n_m1;
  logic [RI-1:0] last_idx;
  logic [PW-1:0] mlen;
  assign out_free = !m_vld_q || m_tready_i;
  assign take_a   = (pa_q != ea_q) &&
                    ((pb_q == eb_q) || ($signed(el_rdata0) <= $signed(el_rdata1)));
  assign n_m1     = n_q - RC'(1);
  assign last_idx = n_m1[RI-1:0];
  assign mlen     = w_q - mstart_q;

  // Next state and datapath control
  always_comb begin
    state_d    = state_q;
    run_cnt_d  = run_cnt_q;
    total_d    = total_q;
    open_d     = open_q;
    drop_d     = drop_q;
    tot_out_d  = tot_out_q;
    drop_out_d = drop_out_q;
    n_d        = n_q;
    half_d     = half_q;
    nseq_d     = nseq_q;
    i_d        = i_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    have_a_d   = have_a_q;
    have_b_d   = have_b_q;
    a_idx_d    = a_idx_q;
    b_idx_d    = b_idx_q;
    a_len_d    = a_len_q;
    b_len_d    = b_len_q;
    a_start_d  = a_start_q;
    b_start_d  = b_start_q;
    a_seq_d    = a_seq_q;
    b_seq_d    = b_seq_q;
    pa_d       = pa_q;
    ea_d       = ea_q;
    pb_d       = pb_q;
    eb_d       = eb_q;
    w_d        = w_q;
    mstart_d   = mstart_q;
    final_d    = final_q;
    fwd_d      = fwd_q;
    fixa_d     = fixa_q;
    k_d        = k_q;
    m_vld_d    = m_vld_q && !m_tready_i;
    m_data_d   = m_data_q;
    m_last_d   = m_last_q;
    m_user_d   = m_user_q;
    el_we      = 1'b0;
    el_waddr   = dst_off + AW'(w_q);
    el_wdata   = take_a ? el_rdata0 : el_rdata1;
    el_raddr0  = src_off + AW'(pa_q);
    el_raddr1  = src_off + AW'(pb_q);
    tb_we      = 1'b0;
    tb_waddr   = i_q[RI-1:0];
    tb_wdata   = {e_seq, e_len, w_q};
    tb_raddr   = i_q[RI-1:0];

    unique case (state_q)
      omts_pkg::ST_IDLE: begin
        if (s_tvalid_i) begin
          unique case (s_tuser_i)
            omts_pkg::CMD_PUSH: begin
              if (total_q < PW'(MAX_ELEMS)) begin
                el_we    = 1'b1;
                el_waddr = AW'(total_q);
                el_wdata = s_tdata_i;
                total_d  = total_q + PW'(1);
                open_d   = open_q + PW'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            omts_pkg::CMD_CLOSE: begin
              tb_we     = close_wr;
              tb_waddr  = run_cnt_q[RI-1:0];
              tb_wdata  = {SW'(run_cnt_q), open_q, total_q - open_q};
              run_cnt_d = rc_cl;
              total_d   = tot_cl;
              drop_d    = drop_cl;
              open_d    = '0;
            end
            omts_pkg::CMD_FINISH: begin
              tb_we      = close_wr;
              tb_waddr   = run_cnt_q[RI-1:0];
              tb_wdata   = {SW'(run_cnt_q), open_q, total_q - open_q};
              tot_out_d  = tot_cl;
              drop_out_d = drop_cl;
              n_d        = rc_cl;
              half_d     = 1'b0;
              w_d        = '0;
              k_d        = '0;
              nseq_d     = SW'(rc_cl);
              run_cnt_d  = '0;
              total_d    = '0;
              open_d     = '0;
              drop_d     = 1'b0;
              i_d        = '0;
              have_a_d   = 1'b0;
              have_b_d   = 1'b0;
              state_d    = (rc_cl > RC'(1)) ? omts_pkg::ST_SCAN : omts_pkg::ST_O_RD;
            end
            default: ;
          endcase
        end
      end

      // Find the two runs that come first by length and age
      omts_pkg::ST_SCAN: begin
        if (i_q != n_q) begin
          rd_vld_d = 1'b1;
          rd_idx_d = i_q[RI-1:0];
          i_d      = i_q + RC'(1);
        end
        if (rd_vld_q) begin
          if (!have_a_q) begin
            have_a_d = 1'b1;
            a_idx_d = rd_idx_q; a_len_d = e_len; a_start_d = e_start; a_seq_d = e_seq;
          end else if (run_before(e_len, e_seq, a_len_q, a_seq_q)) begin
            have_b_d = 1'b1;
            b_idx_d = a_idx_q; b_len_d = a_len_q; b_start_d = a_start_q; b_seq_d = a_seq_q;
            a_idx_d = rd_idx_q; a_len_d = e_len; a_start_d = e_start; a_seq_d = e_seq;
          end else if (!have_b_q || run_before(e_len, e_seq, b_len_q, b_seq_q)) begin
            have_b_d = 1'b1;
            b_idx_d = rd_idx_q; b_len_d = e_len; b_start_d = e_start; b_seq_d = e_seq;
          end
        end else if (i_q == n_q) begin
          i_d     = '0;
          state_d = omts_pkg::ST_CP_SEL;
        end
      end

      // Pick the next run to copy, or start the merge of the chosen pair
      omts_pkg::ST_CP_SEL: begin
        if (i_q == n_q) begin
          pa_d     = a_start_q;
          ea_d     = a_start_q + a_len_q;
          pb_d     = b_start_q;
          eb_d     = b_start_q + b_len_q;
          mstart_d = w_q;
          final_d  = 1'b1;
          state_d  = omts_pkg::ST_MRD;
        end else if ((i_q[RI-1:0] == a_idx_q) || (i_q[RI-1:0] == b_idx_q)) begin
          i_d = i_q + RC'(1);
        end else begin
          state_d = omts_pkg::ST_CP_GET;
        end
      end

      // Relocate this run to the destination half
      omts_pkg::ST_CP_GET: begin
        tb_we    = 1'b1;
        tb_wdata = {e_seq, e_len, w_q};
        pa_d     = e_start;
        ea_d     = e_start + e_len;
        pb_d     = '0;
        eb_d     = '0;
        final_d  = 1'b0;
        i_d      = i_q + RC'(1);
        state_d  = omts_pkg::ST_MRD;
      end

      // Fetch both heads
      omts_pkg::ST_MRD: begin
        if ((pa_q == ea_q) && (pb_q == eb_q)) begin
          state_d = final_q ? omts_pkg::ST_FIX_A : omts_pkg::ST_CP_SEL;
        end else begin
          state_d = omts_pkg::ST_MCMP;
        end
      end

      // Move the smaller head, first run on ties
      omts_pkg::ST_MCMP: begin
        el_we = 1'b1;
        w_d   = w_q + PW'(1);
        if (take_a) begin
          pa_d = pa_q + PW'(1);
        end else begin
          pb_d = pb_q + PW'(1);
        end
        state_d = omts_pkg::ST_MRD;
      end

      // Store the merged run in the first slot, then fill the hole left by the second
      omts_pkg::ST_FIX_A: begin
        tb_we    = 1'b1;
        tb_waddr = a_idx_q;
        tb_wdata = {nseq_q, mlen, mstart_q};
        nseq_d   = nseq_q + SW'(1);
        tb_raddr = last_idx;
        fwd_d    = (a_idx_q == last_idx);
        fixa_d   = {nseq_q, mlen, mstart_q};
        state_d  = (b_idx_q == last_idx) ? omts_pkg::ST_PASS_END : omts_pkg::ST_FIX_B;
      end

      omts_pkg::ST_FIX_B: begin
        tb_we    = 1'b1;
        tb_waddr = b_idx_q;
        tb_wdata = fwd_q ? fixa_q : tb_rdata;
        state_d  = omts_pkg::ST_PASS_END;
      end

      omts_pkg::ST_PASS_END: begin
        n_d      = n_m1;
        half_d   = ~half_q;
        w_d      = '0;
        i_d      = '0;
        have_a_d = 1'b0;
        have_b_d = 1'b0;
        state_d  = (n_m1 > RC'(1)) ? omts_pkg::ST_SCAN : omts_pkg::ST_O_RD;
      end

      // Emit the final run, or the marked empty result
      omts_pkg::ST_O_RD: begin
        el_raddr0 = src_off + AW'(k_q);
        if (tot_out_q == '0) begin
          if (out_free) begin
            m_vld_d  = 1'b1;
            m_data_d = '0;
            m_last_d = 1'b1;
            m_user_d = '0;
            m_user_d[omts_pkg::UserEmptyBit] = 1'b1;
            m_user_d[omts_pkg::UserOvflBit]  = drop_out_q;
            state_d  = omts_pkg::ST_IDLE;
          end
        end else begin
          state_d = omts_pkg::ST_O_WAIT;
        end
      end

      omts_pkg::ST_O_WAIT: begin
        el_raddr0 = src_off + AW'(k_q);
        if (out_free) begin
          m_vld_d  = 1'b1;
          m_data_d = el_rdata0;
          m_last_d = (k_q == tot_out_q - PW'(1));
          m_user_d = '0;
          m_user_d[omts_pkg::UserOvflBit] = drop_out_q;
          k_d      = k_q + PW'(1);
          state_d  = (k_q == tot_out_q - PW'(1)) ? omts_pkg::ST_IDLE : omts_pkg::ST_O_RD;
        end
      end

      default: state_d = omts_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= omts_pkg::ST_IDLE;
      run_cnt_q <= '0;
      total_q   <= '0;
      open_q    <= '0;
      drop_q    <= 1'b0;
      rd_vld_q  <= 1'b0;
      m_vld_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      run_cnt_q <= run_cnt_d;
      total_q   <= total_d;
      open_q    <= open_d;
      drop_q    <= drop_d;
      rd_vld_q  <= rd_vld_d;
      m_vld_q   <= m_vld_d;
    end
  end

  // Working registers of the merge passes and the output stage
  always_ff @(posedge clk_i) begin
    tot_out_q  <= tot_out_d;
    drop_out_q <= drop_out_d;
    n_q        <= n_d;
    half_q     <= half_d;
    nseq_q     <= nseq_d;
    i_q        <= i_d;
    rd_idx_q   <= rd_idx_d;
    have_a_q   <= have_a_d;
    have_b_q   <= have_b_d;
    a_idx_q    <= a_idx_d;
    b_idx_q    <= b_idx_d;
    a_len_q    <= a_len_d;
    b_len_q    <= b_len_d;
    a_start_q  <= a_start_d;
    b_start_q  <= b_start_d;
    a_seq_q    <= a_seq_d;
    b_seq_q    <= b_seq_d;
    pa_q       <= pa_d;
    ea_q       <= ea_d;
    pb_q       <= pb_d;
    eb_q       <= eb_d;
    w_q        <= w_d;
    mstart_q   <= mstart_d;
    final_q    <= final_d;
    fwd_q      <= fwd_d;
    fixa_q     <= fixa_d;
    k_q        <= k_d;
    m_data_q   <= m_data_d;
    m_last_q   <= m_last_d;
    m_user_q   <= m_user_d;
  end

  assign s_tready_o = (state_q == omts_pkg::ST_IDLE);
  assign m_tvalid_o = m_vld_q;
  assign m_tdata_o  = m_data_q;
  assign m_tlast_o  = m_last_q;
  assign m_tuser_o  = m_user_q;

  // Element count never passes the store capacity
  a_total_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q <= PW'(MAX_ELEMS)) && (open_q <= total_q))
    else $error("element count beyond capacity");

  // Merge pointers stay inside their runs
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == omts_pkg::ST_MCMP) |-> ((pa_q <= ea_q) && (pb_q <= eb_q)))
    else $error("merge pointer past end of run");

  // The merged run holds exactly both source runs
  a_merge_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == omts_pkg::ST_FIX_A) |-> (mlen == a_len_q + b_len_q))
    else $error("merged run length mismatch");

endmodule

@@ hw/rtl/omts_elem_mem.sv @@
// Element store: one write port, two registered read ports.
`timescale 1ns / 1ps
module omts_elem_mem #(
  parameter int Depth = 128,
  parameter int AddrW = 7
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [omts_pkg::DataW-1:0] wdata_i,
  input  logic [AddrW-1:0]           raddr0_i,
  input  logic [AddrW-1:0]           raddr1_i,
  output logic [omts_pkg::DataW-1:0] rdata0_o,
  output logic [omts_pkg::DataW-1:0] rdata1_o
);

  logic [omts_pkg::DataW-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports
  always_ff @(posedge clk_i) begin
    rdata0_o <= mem[raddr0_i];
    rdata1_o <= mem[raddr1_i];
  end

endmodule

@@ hw/rtl/omts_run_tab.sv @@
// Run table: start, length and age of each stored run, one read and one write port.
`timescale 1ns / 1ps
module omts_run_tab #(
  parameter int Depth = 16,
  parameter int IdxW  = 4,
  parameter int DataW = 18
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IdxW-1:0]  waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [IdxW-1:0]  raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
